/* rtl/sht_pkg.sv */
`default_nettype none

package sht_pkg;

    // Width of the entry count on the result channel
    localparam int TOTAL_W = 9;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // One table entry as held in a cell
    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] addr;
        logic [31:0] size;
    } entry_t;

    // Lookup result travelling down the cell row towards cell 0
    typedef struct packed {
        logic        found;
        logic [31:0] addr;
        logic [31:0] size;
    } res_t;

    // Strobes broadcast from the controller to every cell
    typedef struct packed {
        logic ins_en;
        logic look_load;
        logic look_shift;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/sorted_hash_table_lookup.sv */
// Sorted file table: a row of TABLE_DEPTH cells, each holding one entry of hash, block
// address and byte size, kept in ascending hash order. Clear, insert and the unused op
// set their registered result on acceptance, so one follows another every cycle while
// the result is taken; an insert compares the key in every cell at once and shifts the
// larger entries one place along the row. A full table flags and drops an insert. A
// lookup marks the first cell whose hash equals the key (the earliest inserted of equal
// hashes) and then folds the result cell by cell towards cell 0; no new operation is
// taken until that walk along the row ends. Only held entries are read, so the table
// needs no clearing after reset.
`default_nettype none

module sorted_hash_table_lookup #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [31:0] s_key_hash,
    input  wire logic [31:0] s_block_addr,
    input  wire logic [31:0] s_byte_size,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [31:0]      m_found_addr,
    output logic [31:0]      m_found_size,
    output logic             m_full_error,
    output logic [8:0]       m_entry_total
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    sht_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      step_reg, step_next;
    logic               m_valid_reg, m_valid_next;
    logic               found_reg, found_next;
    logic [31:0]        faddr_reg, faddr_next;
    logic [31:0]        fsize_reg, fsize_next;
    logic               full_reg, full_next;
    logic [sht_pkg::TOTAL_W-1:0] total_reg, total_next;

    sht_pkg::cell_cmd_t cmd;
    sht_pkg::op_t       op;

    sht_pkg::entry_t    entry_w [TABLE_DEPTH];
    logic               gt_w    [TABLE_DEPTH];
    logic               eq_w    [TABLE_DEPTH];
    sht_pkg::res_t      res_w   [TABLE_DEPTH];

    assign op = sht_pkg::op_t'(s_op);

    // Cell row
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        sht_pkg::entry_t left_entry;
        logic            left_gt;
        logic            left_eq;
        sht_pkg::res_t   right_res;

        if (i == 0) begin : g_head
            assign left_entry = '0;
            assign left_gt    = 1'b0;
            assign left_eq    = 1'b0;
        end else begin : g_body
            assign left_entry = entry_w[i-1];
            assign left_gt    = gt_w[i-1];
            assign left_eq    = eq_w[i-1];
        end

        if (i == TABLE_DEPTH - 1) begin : g_tail
            assign right_res = '0;
        end else begin : g_inner
            assign right_res = res_w[i+1];
        end

        sht_cell #(
            .CW    (CW),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .count      (count_reg),
            .key        (s_key_hash),
            .addr       (s_block_addr),
            .size       (s_byte_size),
            .left_entry (left_entry),
            .left_gt    (left_gt),
            .left_eq    (left_eq),
            .right_res  (right_res),
            .entry      (entry_w[i]),
            .gt         (gt_w[i]),
            .eq         (eq_w[i]),
            .res        (res_w[i])
        );
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sht_pkg::ST_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        found_reg <= found_next;
        faddr_reg <= faddr_next;
        fsize_reg <= fsize_next;
        full_reg  <= full_next;
        total_reg <= total_next;
    end

    // Next state, cell strobes and result
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        found_next   = found_reg;
        faddr_next   = faddr_reg;
        fsize_next   = fsize_reg;
        full_next    = full_reg;
        total_next   = total_reg;
        cmd          = '0;
        s_ready      = 1'b0;

        unique case (state_reg)
            sht_pkg::ST_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
                if (m_valid_reg && m_ready) begin
                    m_valid_next = 1'b0;
                end
                if (s_valid && s_ready) begin
                    found_next = 1'b0;
                    faddr_next = '0;
                    fsize_next = '0;
                    full_next  = 1'b0;
                    unique case (op)
                        sht_pkg::OP_CLEAR: begin
                            count_next   = '0;
                            m_valid_next = 1'b1;
                        end
                        sht_pkg::OP_INSERT: begin
                            if (count_reg == CW'(TABLE_DEPTH)) begin
                                full_next = 1'b1;
                            end else begin
                                cmd.ins_en = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            m_valid_next = 1'b1;
                        end
                        sht_pkg::OP_LOOKUP: begin
                            cmd.look_load = 1'b1;
                            step_next     = (count_reg == '0) ? '0 : count_reg - CW'(1);
                            state_next    = sht_pkg::ST_SCAN;
                        end
                        sht_pkg::OP_NONE: begin
                            m_valid_next = 1'b1;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                    total_next = sht_pkg::TOTAL_W'(count_next);
                end
            end
            sht_pkg::ST_SCAN: begin
                // Fold results towards cell 0 until every held entry has been seen
                if (step_reg == '0) begin
                    found_next   = res_w[0].found;
                    faddr_next   = res_w[0].addr;
                    fsize_next   = res_w[0].size;
                    total_next   = sht_pkg::TOTAL_W'(count_reg);
                    m_valid_next = 1'b1;
                    state_next   = sht_pkg::ST_IDLE;
                end else begin
                    cmd.look_shift = 1'b1;
                    step_next      = step_reg - CW'(1);
                end
            end
            default: begin
                state_next = sht_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = found_reg;
    assign m_found_addr  = faddr_reg;
    assign m_found_size  = fsize_reg;
    assign m_full_error  = full_reg;
    assign m_entry_total = total_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == sht_pkg::OP_INSERT && count_reg != CW'(TABLE_DEPTH))
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not add one entry");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == sht_pkg::OP_CLEAR) |=> count_reg == '0)
        else $error("clear left entries behind");

    a_found_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> !m_full_error)
        else $error("lookup hit flagged as full");

    a_scan_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sht_pkg::ST_SCAN) |-> (!s_ready && !m_valid_reg))
        else $error("input taken or result shown during lookup scan");
`endif

endmodule

`default_nettype wire

/* rtl/sht_cell.sv */
`default_nettype none

module sht_cell #(
    parameter int CW    = 9,
    parameter int INDEX = 0
) (
    input  wire logic               aclk,
    input  wire sht_pkg::cell_cmd_t cmd,
    input  wire logic [CW-1:0]      count,
    input  wire logic [31:0]        key,
    input  wire logic [31:0]        addr,
    input  wire logic [31:0]        size,
    input  wire sht_pkg::entry_t    left_entry,
    input  wire logic               left_gt,
    input  wire logic               left_eq,
    input  wire sht_pkg::res_t      right_res,
    output sht_pkg::entry_t         entry,
    output logic                    gt,
    output logic                    eq,
    output sht_pkg::res_t           res
);

    sht_pkg::entry_t entry_reg;
    sht_pkg::res_t   res_reg;
    logic            valid;
    logic            first;

    // Cell holds a live entry while its place lies below the count
    assign valid = CW'(INDEX) < count;
    assign gt    = valid && (entry_reg.hash > key);
    assign eq    = valid && (entry_reg.hash == key);
    // First of any run of equal hashes is the earliest inserted
    assign first = eq && !left_eq;

    // Insert: shift right behind a larger left neighbour, else take the new entry here if own entry is larger or empty
    always_ff @(posedge aclk) begin
        if (cmd.ins_en) begin
            if (left_gt) begin
                entry_reg <= left_entry;
            end else if (gt || !valid) begin
                entry_reg <= '{hash: key, addr: addr, size: size};
            end
        end
    end

    // Lookup: load own match, then fold in the neighbour's result on each shift strobe
    always_ff @(posedge aclk) begin
        if (cmd.look_load) begin
            if (first) begin
                res_reg <= '{found: 1'b1, addr: entry_reg.addr, size: entry_reg.size};
            end else begin
                res_reg <= '0;
            end
        end else if (cmd.look_shift) begin
            res_reg <= res_reg | right_res;
        end
    end

    assign entry = entry_reg;
    assign res   = res_reg;

endmodule

`default_nettype wire
